FILE: rtl/rmsi_pkg.sv
// shared constants and helpers for the running median insertion-sort block
// no dependencies; used by rmsi_or_tree and running_median_sorted_insert_top
`timescale 1ns / 1ps

package rmsi_pkg;

    // fixed field widths at the ports
    localparam int SAMPLE_W = 32;
    localparam int MEDIAN_W = 33;
    localparam int COUNT_W  = 7;

    // defaults for the top-level parameters
    localparam int CAPACITY_DEF    = 64;
    localparam int SAMPLE_BITS_DEF = 32;

    // fan-in of one level of the selection tree
    localparam int TREE_RADIX = 8;

    // number of registered levels needed to reduce n leaves to one
    function automatic int tree_levels(input int n);
        int lv;
        int rem;
        lv  = 1;
        rem = n;
        while (rem > TREE_RADIX)
        begin
            rem = (rem + TREE_RADIX - 1) / TREE_RADIX;
            lv  = lv + 1;
        end
        return lv;
    endfunction

endpackage

FILE: rtl/rmsi_cell.sv
// one slot of the sorted chain: holds a sample, shifts up on insert
// and offers its value to the median selection when picked
// depends on nothing but its parameters
`timescale 1ns / 1ps

module rmsi_cell #(
    parameter int SAMPLE_BITS = 32,
    parameter int CNT_W       = 7,
    parameter int IDX         = 0
) (
    input  logic                          clk,
    input  logic                          insert,
    input  logic signed [SAMPLE_BITS-1:0] sample,
    input  logic [CNT_W-1:0]              count,
    input  logic [CNT_W-1:0]              lo_idx,
    input  logic [CNT_W-1:0]              hi_idx,
    input  logic                          pick_en,
    input  logic signed [SAMPLE_BITS-1:0] prev_val,
    input  logic                          prev_take,
    output logic signed [SAMPLE_BITS-1:0] val,
    output logic                          take,
    output logic [2*SAMPLE_BITS-1:0]      pick
);

    localparam logic [CNT_W-1:0] IDX_C = CNT_W'(IDX);

    logic signed [SAMPLE_BITS-1:0] val_reg;
    logic signed [SAMPLE_BITS-1:0] val_next;
    logic                          pick_lo;
    logic                          pick_hi;

    // empty slots count as greater, so the first empty slot takes the sample or the value shifted up into it
    assign take = (count <= IDX_C) || (sample < val_reg);
    assign val  = val_reg;

    always_comb
    begin
        val_next = val_reg;
        if (take)
        begin
            val_next = prev_take ? prev_val : sample;
        end
    end

    always_ff @(posedge clk)
    begin
        if (insert)
        begin
            val_reg <= val_next;
        end
    end

    assign pick_lo = pick_en && (lo_idx == IDX_C);
    assign pick_hi = pick_en && (hi_idx == IDX_C);
    assign pick    = {val_reg & {SAMPLE_BITS{pick_lo}}, val_reg & {SAMPLE_BITS{pick_hi}}};

endmodule

FILE: rtl/rmsi_or_tree.sv
// registered or-reduction tree that gathers the picked cell values
// one register level per rmsi_pkg::TREE_RADIX-way group; uses rmsi_pkg
`timescale 1ns / 1ps

module rmsi_or_tree #(
    parameter int N_IN  = 64,
    parameter int WIDTH = 64
) (
    input  logic             clk,
    input  logic [WIDTH-1:0] leaf [N_IN],
    output logic [WIDTH-1:0] root
);

    localparam int R      = rmsi_pkg::TREE_RADIX;
    localparam int GROUPS = (N_IN + R - 1) / R;

    logic [WIDTH-1:0] grp_reg  [GROUPS];
    logic [WIDTH-1:0] grp_next [GROUPS];

    for (genvar g = 0; g < GROUPS; g++)
    begin : g_grp
        localparam int BASE = g * R;
        localparam int CNT  = ((N_IN - BASE) < R) ? (N_IN - BASE) : R;

        always_comb
        begin
            grp_next[g] = '0;
            for (int k = 0; k < CNT; k++)
            begin
                grp_next[g] = grp_next[g] | leaf[BASE + k];
            end
        end

        always_ff @(posedge clk)
        begin
            grp_reg[g] <= grp_next[g];
        end
    end

    if (GROUPS == 1)
    begin : g_last
        assign root = grp_reg[0];
    end
    else
    begin : g_up
        rmsi_or_tree #(
            .N_IN  (GROUPS),
            .WIDTH (WIDTH)
        ) u_up (
            .clk  (clk),
            .leaf (grp_reg),
            .root (root)
        );
    end

endmodule

FILE: rtl/running_median_sorted_insert_top.sv
// top level of the running median block: chain of sorted cells, selection tree,
// handshake control and output register; uses rmsi_pkg, rmsi_cell, rmsi_or_tree
`timescale 1ns / 1ps
//
// channel | signals                                  | direction
// --------+------------------------------------------+----------
// input   | in_valid, in_stall, mode, sample         | in
// output  | out_valid, out_stall, median_twice,      | out
//         | stored_count, refused                    |
//
// the insert itself is done in the cell chain; the median is then gathered
// through the L levels of the 8-way selection tree (2 at a capacity of 64).
// one item is in flight at a time; in_stall is high while it is.
// a finished result waits in the output register, so the next transfer is
// taken while out_stall holds it. reset empties the store; cell contents
// are not cleared, entries above the fill count are never selected.

module running_median_sorted_insert_top #(
    parameter int CAPACITY    = rmsi_pkg::CAPACITY_DEF,
    parameter int SAMPLE_BITS = rmsi_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic                                 mode,
    input  logic signed [rmsi_pkg::SAMPLE_W-1:0] sample,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic signed [rmsi_pkg::MEDIAN_W-1:0] median_twice,
    output logic [rmsi_pkg::COUNT_W-1:0]         stored_count,
    output logic                                 refused
);

    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int LAT    = rmsi_pkg::tree_levels(CAPACITY);
    localparam int WAIT_W = $clog2(LAT + 1);
    localparam int PICK_W = 2 * SAMPLE_BITS;

    localparam logic [CNT_W-1:0]  CAP_C = CNT_W'(CAPACITY);
    localparam logic [WAIT_W-1:0] LAT_C = WAIT_W'(LAT);

    logic                          busy_reg, busy_next;
    logic [WAIT_W-1:0]             wait_reg, wait_next;
    logic [CNT_W-1:0]              count_reg, count_next;
    logic                          refused_reg, refused_next;
    logic                          out_valid_reg, out_valid_next;
    logic signed [rmsi_pkg::MEDIAN_W-1:0] median_reg;
    logic [rmsi_pkg::COUNT_W-1:0]  stored_reg;
    logic                          refused_out_reg;

    logic                          accept;
    logic                          full;
    logic                          do_insert;
    logic                          out_load;
    logic signed [SAMPLE_BITS-1:0] smp;
    logic [CNT_W-1:0]              cnt_m1;
    logic [CNT_W-1:0]              lo_idx;
    logic [CNT_W-1:0]              hi_idx;
    logic                          pick_en;
    logic [CNT_W+rmsi_pkg::COUNT_W-1:0] count_ext;

    logic signed [SAMPLE_BITS-1:0] cell_val  [CAPACITY];
    logic                          cell_take [CAPACITY];
    logic [PICK_W-1:0]             cell_pick [CAPACITY];
    logic [PICK_W-1:0]             root;
    logic signed [SAMPLE_BITS:0]   mid_sum;

    assign smp       = sample[SAMPLE_BITS-1:0];
    assign accept    = in_valid && !busy_reg;
    assign full      = (count_reg == CAP_C);
    assign do_insert = accept && !mode && !full;
    assign in_stall  = busy_reg;

    // middle positions: lower (n-1)/2, upper n/2, same slot for odd n
    assign cnt_m1  = count_reg - CNT_W'(1);
    assign lo_idx  = cnt_m1 >> 1;
    assign hi_idx  = count_reg >> 1;
    assign pick_en = (count_reg != '0);

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic signed [SAMPLE_BITS-1:0] prev_val;
        logic                          prev_take;

        if (i == 0)
        begin : g_head
            assign prev_val  = smp;
            assign prev_take = 1'b0;
        end
        else
        begin : g_link
            assign prev_val  = cell_val[i-1];
            assign prev_take = cell_take[i-1];
        end

        rmsi_cell #(
            .SAMPLE_BITS (SAMPLE_BITS),
            .CNT_W       (CNT_W),
            .IDX         (i)
        ) u_cell (
            .clk       (clk),
            .insert    (do_insert),
            .sample    (smp),
            .count     (count_reg),
            .lo_idx    (lo_idx),
            .hi_idx    (hi_idx),
            .pick_en   (pick_en),
            .prev_val  (prev_val),
            .prev_take (prev_take),
            .val       (cell_val[i]),
            .take      (cell_take[i]),
            .pick      (cell_pick[i])
        );
    end

    rmsi_or_tree #(
        .N_IN  (CAPACITY),
        .WIDTH (PICK_W)
    ) u_tree (
        .clk  (clk),
        .leaf (cell_pick),
        .root (root)
    );

    assign mid_sum = $signed({root[PICK_W-1], root[PICK_W-1:SAMPLE_BITS]})
                   + $signed({root[SAMPLE_BITS-1], root[SAMPLE_BITS-1:0]});

    // result leaves the tree once all levels have settled and the slot is free
    assign out_load = busy_reg && (wait_reg == '0) && (!out_valid_reg || !out_stall);

    always_comb
    begin
        busy_next      = busy_reg;
        wait_next      = wait_reg;
        count_next     = count_reg;
        refused_next   = refused_reg;
        out_valid_next = out_valid_reg;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        if (accept)
        begin
            busy_next    = 1'b1;
            wait_next    = LAT_C;
            refused_next = !mode && full;
            priority if (mode)
            begin
                count_next = '0;
            end
            else if (!full)
            begin
                count_next = count_reg + CNT_W'(1);
            end
            else
            begin
                count_next = count_reg;
            end
        end
        else if (busy_reg && (wait_reg != '0))
        begin
            wait_next = wait_reg - WAIT_W'(1);
        end

        if (out_load)
        begin
            busy_next      = 1'b0;
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            wait_reg      <= '0;
            count_reg     <= '0;
            refused_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            wait_reg      <= wait_next;
            count_reg     <= count_next;
            refused_reg   <= refused_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign count_ext = {{rmsi_pkg::COUNT_W{1'b0}}, count_reg};

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            median_reg      <= rmsi_pkg::MEDIAN_W'(mid_sum);
            stored_reg      <= count_ext[rmsi_pkg::COUNT_W-1:0];
            refused_out_reg <= refused_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign median_twice = median_reg;
    assign stored_count = stored_reg;
    assign refused      = refused_out_reg;

endmodule
